// ===== rtl/mstp_pkg.sv =====
// Shared types and constants for the minimum spanning tree (Prim) unit.
// Used by mstp_front, mstp_back and min_spanning_tree_prim_unit.
package mstp_pkg;

	localparam int VERT_W           = 6;
	localparam int WEIGHT_W         = 16;
	localparam int CFG_W            = 7;
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic CFG_VCOUNT = 1'b0;
	localparam logic CFG_SOURCE = 1'b1;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_RUN,
		CMD_CLEAR
	} cmd_t;

	typedef struct packed {
		logic [1:0]                 action;
		logic [VERT_W-1:0]          vertex_a;
		logic [VERT_W-1:0]          vertex_b;
		logic signed [WEIGHT_W-1:0] weight;
	} in_item_t;

	typedef struct packed {
		logic [VERT_W-1:0]          vertex;
		logic [VERT_W-1:0]          parent;
		logic                       has_parent;
		logic signed [WEIGHT_W-1:0] key;
		logic                       edges_dropped;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic [VERT_W-1:0]          a;
		logic [VERT_W-1:0]          b;
		logic signed [WEIGHT_W-1:0] w;
	} edge_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic [VERT_W-1:0]          a;
		logic [VERT_W-1:0]          b;
		logic signed [WEIGHT_W-1:0] w;
	} cmd_item_t;

	typedef struct packed {
		logic      valid;
		cmd_item_t item;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EDGE_RD,
		ST_EDGE_CHK,
		ST_KEY_UPD,
		ST_EMIT_RD,
		ST_EMIT_WR
	} bst_t;

endpackage

// ===== rtl/mstp_front.sv =====
// Front end: accepts input beats, decodes the action, drops unused codes
// and holds commands in a short queue. Depends on mstp_pkg.
module mstp_front #(
	parameter int DEPTH = mstp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mstp_pkg::in_item_t in_data,
	output mstp_pkg::q_head_t  head,
	input  logic               pop
);
	import mstp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_item_t      q_mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           accept;
	logic           keep;
	logic           push;
	cmd_item_t      cls;

	assign in_stall = (cnt_q == CW'(DEPTH));
	assign accept   = in_valid && !in_stall;
	assign push     = accept && keep;

	always_comb begin
		cls.a = in_data.vertex_a;
		cls.b = in_data.vertex_b;
		cls.w = in_data.weight;
		keep  = 1'b1;
		case (in_data.action)
			ACT_ADD:   cls.cmd = CMD_ADD;
			ACT_RUN:   cls.cmd = CMD_RUN;
			ACT_CLEAR: cls.cmd = CMD_CLEAR;
			default: begin
				cls.cmd = CMD_ADD;
				keep    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count over depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != CW'(DEPTH))) else $error("push into full queue");

endmodule

// ===== rtl/mstp_back.sv =====
// Back end: edge store, configuration registers and the Prim sequencer
// with its key and parent memories and the output register. Depends on mstp_pkg.
module mstp_back #(
	parameter int MAX_VERTICES = mstp_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = mstp_pkg::DEF_MAX_EDGES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mstp_pkg::q_head_t           head,
	output logic                        pop,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mstp_pkg::CFG_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mstp_pkg::out_item_t         out_data
);
	import mstp_pkg::*;

	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int VIW = $clog2(MAX_VERTICES);

	edge_t                      edge_mem [MAX_EDGES];
	logic signed [WEIGHT_W-1:0] key_mem  [MAX_VERTICES];
	logic [VERT_W-1:0]          par_mem  [MAX_VERTICES];

	edge_t                      edge_rd_q;
	logic signed [WEIGHT_W-1:0] key_rd_q;
	logic [VERT_W-1:0]          par_rd_q;

	bst_t                       state_q, state_d;
	logic [ECW-1:0]             edge_count_q;
	logic                       ovf_q;
	logic [CFG_W-1:0]           vcount_q;
	logic [VERT_W-1:0]          source_q;
	logic [VERT_W-1:0]          u_q;
	logic [CFG_W-1:0]           step_q;
	logic [CFG_W-1:0]           idx_q;
	logic                       pend_s1;
	logic [VERT_W-1:0]          idx_s1;
	logic                       found_q;
	logic                       found_r_q;
	logic signed [WEIGHT_W-1:0] best_key_q;
	logic [VERT_W-1:0]          best_idx_q;
	logic [ECW-1:0]             e_q;
	logic [VERT_W-1:0]          v_q;
	logic signed [WEIGHT_W-1:0] ew_q;
	logic [MAX_VERTICES-1:0]    reached_q;
	logic [MAX_VERTICES-1:0]    visited_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic [CFG_W-1:0]           n_eff;
	logic [VERT_W-1:0]          src_eff;
	logic [VIW-1:0]             key_raddr;
	logic                       edge_we;
	logic                       key_we;
	logic                       out_load;
	logic                       run_start;
	logic                       scan_issue;
	logic                       scan_done;
	logic                       run_done;
	logic                       hit_a;
	logic                       hit;
	logic [VERT_W-1:0]          cand_v;
	logic                       relax_ok;
	logic                       take;
	logic                       hp;
	logic                       cand_r;

	always_comb begin
		if (vcount_q == '0)                              n_eff = CFG_W'(1);
		else if (vcount_q > CFG_W'(MAX_VERTICES))        n_eff = CFG_W'(MAX_VERTICES);
		else                                             n_eff = vcount_q;
	end
	assign src_eff = ({1'b0, source_q} >= n_eff) ? '0 : source_q;

	assign hit_a    = (edge_rd_q.a == u_q);
	assign hit      = hit_a || (edge_rd_q.b == u_q);
	assign cand_v   = hit_a ? edge_rd_q.b : edge_rd_q.a;
	assign relax_ok = hit && ({1'b0, cand_v} < n_eff) && !visited_q[cand_v[VIW-1:0]];

	assign cand_r = reached_q[idx_s1[VIW-1:0]];
	assign take   = pend_s1 && !visited_q[idx_s1[VIW-1:0]] && (!found_q
		|| (cand_r && !found_r_q) || (cand_r && found_r_q && key_rd_q < best_key_q));

	assign scan_issue = (state_q == ST_SCAN) && (idx_q < n_eff);
	assign scan_done  = (state_q == ST_SCAN) && (idx_q == n_eff) && !pend_s1;
	assign run_done   = ((step_q + 1'b1) == n_eff);
	assign hp         = (u_q != src_eff) && reached_q[u_q[VIW-1:0]];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (head.valid && head.item.cmd == CMD_RUN) state_d = ST_EDGE_RD;
			ST_SCAN:     if (scan_done) state_d = ST_EDGE_RD;
			ST_EDGE_RD:  state_d = (e_q == edge_count_q) ? ST_EMIT_RD : ST_EDGE_CHK;
			ST_EDGE_CHK: state_d = relax_ok ? ST_KEY_UPD : ST_EDGE_RD;
			ST_KEY_UPD:  state_d = ST_EDGE_RD;
			ST_EMIT_RD:  state_d = ST_EMIT_WR;
			ST_EMIT_WR:  if (out_load) state_d = run_done ? ST_IDLE : ST_SCAN;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		edge_we   = 1'b0;
		key_we    = 1'b0;
		out_load  = 1'b0;
		run_start = 1'b0;
		key_raddr = u_q[VIW-1:0];
		case (state_q)
			ST_IDLE: begin
				pop       = head.valid;
				edge_we   = head.valid && head.item.cmd == CMD_ADD
					&& edge_count_q < ECW'(MAX_EDGES);
				run_start = head.valid && head.item.cmd == CMD_RUN;
			end
			ST_SCAN:     if (scan_issue) key_raddr = idx_q[VIW-1:0];
			ST_EDGE_CHK: key_raddr = cand_v[VIW-1:0];
			ST_KEY_UPD:  key_we = !reached_q[v_q[VIW-1:0]] || (ew_q < key_rd_q);
			ST_EMIT_WR:  out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_count_q[EAW-1:0]] <= '{a: head.item.a, b: head.item.b,
			w: head.item.w};
		edge_rd_q <= edge_mem[e_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[v_q[VIW-1:0]] <= ew_q;
			par_mem[v_q[VIW-1:0]] <= u_q;
		end
		key_rd_q <= key_mem[key_raddr];
		par_rd_q <= par_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE_CHK) begin
			v_q  <= cand_v;
			ew_q <= edge_rd_q.w;
		end
		if (take) begin
			best_key_q <= key_rd_q;
			best_idx_q <= idx_s1;
		end
		idx_s1 <= idx_q[VERT_W-1:0];
		if (out_load) begin
			out_q.vertex        <= u_q;
			out_q.parent        <= hp ? par_rd_q : '0;
			out_q.has_parent    <= hp;
			out_q.key           <= hp ? key_rd_q : '0;
			out_q.edges_dropped <= ovf_q;
			out_q.last          <= run_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			edge_count_q <= '0;
			ovf_q        <= 1'b0;
			vcount_q     <= CFG_W'(64);
			source_q     <= '0;
			u_q          <= '0;
			step_q       <= '0;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			found_q      <= 1'b0;
			found_r_q    <= 1'b0;
			e_q          <= '0;
			reached_q    <= '0;
			visited_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_VCOUNT) vcount_q <= cfg_data;
				if (cfg_index == CFG_SOURCE) source_q <= cfg_data[VERT_W-1:0];
			end
			if (pop && head.item.cmd == CMD_ADD) begin
				if (edge_count_q < ECW'(MAX_EDGES)) edge_count_q <= edge_count_q + 1'b1;
				else                                 ovf_q <= 1'b1;
			end
			if (pop && head.item.cmd == CMD_CLEAR) begin
				edge_count_q <= '0;
				ovf_q        <= 1'b0;
			end
			if (run_start) begin
				reached_q          <= '0;
				visited_q          <= '0;
				visited_q[src_eff[VIW-1:0]] <= 1'b1;
				u_q                <= src_eff;
				step_q             <= '0;
				e_q                <= '0;
			end
			pend_s1 <= scan_issue;
			if (scan_issue) idx_q <= idx_q + 1'b1;
			if (take) begin
				found_q   <= 1'b1;
				found_r_q <= cand_r;
			end
			if (scan_done) begin
				u_q                            <= best_idx_q;
				visited_q[best_idx_q[VIW-1:0]] <= 1'b1;
				e_q                            <= '0;
			end
			if (state_q == ST_EDGE_CHK) e_q <= e_q + 1'b1;
			if (key_we) reached_q[v_q[VIW-1:0]] <= 1'b1;
			if (out_load && !run_done) begin
				step_q  <= step_q + 1'b1;
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (out_load)                    out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= ECW'(MAX_EDGES)) else $error("edge count over store size");
	a_no_visited_upd: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> !visited_q[v_q[VIW-1:0]]) else $error("key write to visited vertex");
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall)) else $error("output overwritten");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE)) else $error("pop while busy");

endmodule

// ===== rtl/min_spanning_tree_prim_unit.sv =====
// Minimum spanning forest unit (Prim's rule) over a loadable edge store.
// Top level: joins mstp_front and mstp_back. Depends on mstp_pkg.
//
// Input channel (in_valid/in_stall/in_data): add edge, run, or clear. Adds
// and clears complete at one beat per cycle while the sequencer is idle;
// unused action codes are dropped. A short command queue sits ahead of the
// sequencer; in_stall rises when full. A run emits one result beat per
// vertex on out_valid/out_stall/out_data, in the order vertices are taken;
// the final beat carries last. Run flow: the first vertex scans the stored
// edges from the dequeue of the run to its result beat; every further vertex
// first scans the n keys, then the edges. These sequential scans of the
// single-read-port key memory and of the edge store set the run time.
// Configuration (cfg_we/cfg_index/cfg_data) writes vertex_count (index 0)
// and source_vertex (index 1) at any edge with cfg_we high.
// Reset empties the edge store, clears the drop flag, sets vertex_count 64 and
// source_vertex 0. While the receiver stalls, the result beat holds and the
// sequencer waits; edge beats keep filling the queue until it is full.
module min_spanning_tree_prim_unit #(
	parameter int MAX_VERTICES = mstp_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = mstp_pkg::DEF_MAX_EDGES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  mstp_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mstp_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mstp_pkg::CFG_W-1:0]  cfg_data
);
	import mstp_pkg::*;

	q_head_t head;
	logic    pop;

	mstp_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.head     (head),
		.pop      (pop)
	);

	mstp_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== sim/mstp_checker.sv =====
// Checker for min_spanning_tree_prim_unit: watches the command, result and
// configuration ports, predicts Prim forest results and compares each beat.
// Depends on mstp_pkg.
module mstp_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  mstp_pkg::in_item_t         in_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  mstp_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [mstp_pkg::CFG_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         results
);
	import mstp_pkg::*;

	edge_t     edges [DEF_MAX_EDGES];
	int        edge_total;
	bit        dropped;
	int        vcount_reg;
	int        source_reg;
	out_item_t forest_q [$];

	assign pending = forest_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %0d: %s got %0d expected %0d", errors + 1, what, got, want);
		errors++;
	endtask

	task automatic grow_forest();
		int n, src, u, v, w, e, s, i;
		bit visited [64];
		bit reached [64];
		int keyv [64];
		int par [64];
		bit found, found_r, hp, hit;
		out_item_t r;
		n = vcount_reg;
		if (n == 0) n = 1;
		if (n > DEF_MAX_VERTICES) n = DEF_MAX_VERTICES;
		src = source_reg;
		if (src >= n) src = 0;
		for (i = 0; i < 64; i++) begin
			visited[i] = 0;
			reached[i] = 0;
			keyv[i] = 0;
			par[i] = 0;
		end
		for (s = 0; s < n; s++) begin
			u = src;
			if (s != 0) begin
				found = 0;
				found_r = 0;
				for (i = 0; i < n; i++) begin
					if (!visited[i] && (!found || (reached[i] && !found_r) ||
							(reached[i] && found_r && keyv[i] < keyv[u]))) begin
						u = i;
						found = 1;
						found_r = reached[i];
					end
				end
			end
			visited[u] = 1;
			for (e = 0; e < edge_total; e++) begin
				for (i = 0; i < 2; i++) begin
					hit = (i == 0) ? (int'(edges[e].a) == u) : (int'(edges[e].b) == u);
					v = (i == 0) ? int'(edges[e].b) : int'(edges[e].a);
					w = int'(edges[e].w);
					if (hit && v < n && !visited[v] && (!reached[v] || w < keyv[v])) begin
						keyv[v] = w;
						par[v] = u;
						reached[v] = 1;
					end
				end
			end
			hp = (u != src) && reached[u];
			r.vertex = VERT_W'(u);
			r.parent = hp ? VERT_W'(par[u]) : '0;
			r.has_parent = hp;
			r.key = hp ? WEIGHT_W'(keyv[u]) : '0;
			r.edges_dropped = dropped;
			r.last = (s + 1 == n);
			forest_q.insert(forest_q.size(), r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t x;
		if (!arst_n) begin
			edge_total = 0;
			dropped = 0;
			vcount_reg = DEF_MAX_VERTICES;
			source_reg = 0;
			errors = 0;
			results = 0;
			forest_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_VCOUNT) vcount_reg = int'(cfg_data);
				else source_reg = int'(cfg_data[VERT_W-1:0]);
			end
			if (in_valid && !in_stall) begin
				case (in_data.action)
					ACT_ADD: begin
						if (edge_total < DEF_MAX_EDGES) begin
							edges[edge_total] = '{in_data.vertex_a, in_data.vertex_b,
								in_data.weight};
							edge_total++;
						end else begin
							dropped = 1;
						end
					end
					ACT_CLEAR: begin
						edge_total = 0;
						dropped = 0;
					end
					ACT_RUN: grow_forest();
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results++;
				if (forest_q.size() == 0) begin
					report("unexpected beat, vertex", int'(out_data.vertex), -1);
				end else begin
					x = forest_q.pop_front();
					if (out_data.vertex !== x.vertex)
						report("vertex", int'(out_data.vertex), int'(x.vertex));
					if (out_data.parent !== x.parent)
						report("parent", int'(out_data.parent), int'(x.parent));
					if (out_data.has_parent !== x.has_parent)
						report("has_parent", int'(out_data.has_parent),
							int'(x.has_parent));
					if (out_data.key !== x.key)
						report("key", int'(out_data.key), int'(x.key));
					if (out_data.edges_dropped !== x.edges_dropped)
						report("edges_dropped", int'(out_data.edges_dropped),
							int'(x.edges_dropped));
					if (out_data.last !== x.last)
						report("last", int'(out_data.last), int'(x.last));
				end
			end
		end
	end
endmodule

// ===== sim/tb_min_spanning_tree_prim_unit.sv =====
// Testbench top for min_spanning_tree_prim_unit: drives edge loads, runs and
// clears with random idling and stalls; mstp_checker predicts and compares.
// Depends on mstp_pkg and mstp_checker.
module tb_min_spanning_tree_prim_unit;
	import mstp_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int QUIET_LIMIT = 40000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               cfg_we;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	int                 errors, pending, results;
	int                 idle_pct, stall_pct, quiet, items, runs, cur_n;

	min_spanning_tree_prim_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mstp_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .results(results)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n) quiet <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(input logic [1:0] act, input int a, input int b, input int w);
		in_valid <= 1'b1;
		in_data <= '{act, a[VERT_W-1:0], b[VERT_W-1:0], w[WEIGHT_W-1:0]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (act != ACT_NONE) items++;
		if (act == ACT_RUN) runs++;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic configure(input int n, input int src);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VCOUNT;
		cfg_data <= n[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_SOURCE;
		cfg_data <= src[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_n = n;
	endtask

	task automatic set_mode();
		case ($urandom_range(0, 3))
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 45; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 45; end
			default: begin idle_pct = 34; stall_pct = 34; end
		endcase
	endtask

	function automatic int pick_vertex(input int n);
		int lim;
		lim = (n < 1) ? 1 : (n > 64 ? 64 : n);
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, lim - 1) : $urandom_range(0, 63);
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 6) - 3;
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	initial begin
		int i, k, n, src;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_VCOUNT;
		cfg_data = '0;
		items = 0;
		runs = 0;
		idle_pct = 0;
		stall_pct = 0;
		cur_n = 64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACT_RUN, 0, 0, 0);
		send(ACT_ADD, 0, 63, -32768);
		send(ACT_ADD, 63, 0, 32767);
		send(ACT_ADD, 5, 5, -1);
		send(ACT_ADD, 1, 0, -7);
		send(ACT_ADD, 2, 1, -7);
		send(ACT_ADD, 2, 0, -7);
		send(ACT_ADD, 42, 21, 0);
		send(ACT_NONE, 63, 63, -1);
		send(ACT_RUN, 63, 63, -1);
		drain();
		configure(4, 10);
		send(ACT_ADD, 3, 1, 5);
		send(ACT_ADD, 1, 3, 4);
		send(ACT_RUN, 0, 0, 0);
		drain();
		configure(0, 63);
		send(ACT_RUN, 0, 0, 0);
		drain();
		configure(127, 63);
		send(ACT_CLEAR, 63, 63, -1);
		send(ACT_ADD, 63, 62, 1);
		send(ACT_RUN, 0, 0, 0);
		drain();
		configure(3, 2);
		for (i = 0; i < DEF_MAX_EDGES + 2; i++)
			send(ACT_ADD, pick_vertex(4), pick_vertex(4), pick_weight());
		send(ACT_RUN, 0, 0, 0);
		send(ACT_CLEAR, 0, 0, 0);
		send(ACT_RUN, 0, 0, 0);
		drain();

		k = items;
		while (items - k < 100) begin
			set_mode();
			if ($urandom_range(0, 99) < 70) begin
				case ($urandom_range(0, 9))
					0: n = 1;
					1: n = 64;
					2: n = 0;
					3: n = $urandom_range(65, 127);
					4: n = $urandom_range(17, 63);
					default: n = $urandom_range(2, 16);
				endcase
				src = $urandom_range(0, 1) ? $urandom_range(0, 63) :
					$urandom_range(0, (n > 0 && n < 64) ? n - 1 : 63);
				configure(n, src);
			end
			if ($urandom_range(0, 1)) send(ACT_CLEAR, $urandom_range(0, 63),
				$urandom_range(0, 63), pick_weight());
			for (i = $urandom_range(0, 24); i > 0; i--) begin
				if ($urandom_range(0, 99) < 8)
					send(ACT_NONE, $urandom_range(0, 63), $urandom_range(0, 63), pick_weight());
				else
					send(ACT_ADD, pick_vertex(cur_n), pick_vertex(cur_n), pick_weight());
			end
			if ($urandom_range(0, 9) != 0) send(ACT_RUN, $urandom_range(0, 63),
				$urandom_range(0, 63), pick_weight());
			drain();
		end

		stall_pct = 0;
		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d commands, %0d runs, %0d result beats checked", items, runs,
			results);
		$display("settings swept vertex counts 0..127, sources in and out of range, overflow");
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
